// File: rtl/ering_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the crc byte step for the eeprom ring log writer
// no dependencies

package ering_pkg;

    // page geometry, must be a power of two
    localparam int PAGE_BYTES = 128;
    localparam int PAGE_LOG   = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = PAGE_LOG + 1;
    localparam int SPAN_W     = (PAGE_W > 8) ? PAGE_W : 8;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // crc-16/ccitt over the metadata block
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [3:0]  META_BYTES = 4'd12;
    localparam logic [7:0]  META_LEN   = 8'd16;
    localparam logic [3:0]  META_EVERY_MASK = 4'hF;

    // register reset values
    localparam logic [31:0] META_MAGIC_RST   = 32'd0;
    localparam logic [15:0] META_ADDRESS_RST = 16'd0;
    localparam logic [15:0] DATA_BASE_RST    = 16'd128;
    localparam logic [16:0] RING_END_RST     = 17'd32768;
    localparam logic [7:0]  RECORD_SIZE_RST  = 8'd16;

    localparam logic [16:0] ADDR_SPACE_END = 17'h10000;
    localparam logic [7:0]  RECORD_MAX     = 8'd128;
    localparam logic [7:0]  RECORD_MIN     = 8'd1;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_META_MAGIC   = 3'd0;
    localparam logic [2:0] CFG_META_ADDRESS = 3'd1;
    localparam logic [2:0] CFG_DATA_BASE    = 3'd2;
    localparam logic [2:0] CFG_RING_END     = 3'd3;
    localparam logic [2:0] CFG_RECORD_SIZE  = 3'd4;

    // input opcodes
    localparam logic OP_RESTORE = 1'b0;
    localparam logic OP_RECORD  = 1'b1;

    typedef enum logic [1:0] {
        CMD_DATA   = 2'd0,
        CMD_META   = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        DESC_RECORD,
        DESC_META,
        DESC_STATUS
    } desc_kind_t;

    typedef enum logic {
        FR_IDLE,
        FR_CHECK
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHUNK0,
        BK_CHUNK1,
        BK_META,
        BK_STATUS
    } back_state_t;

    // effective configuration seen by front and back
    typedef struct packed {
        logic [31:0] meta_magic;
        logic [15:0] meta_address;
        logic [15:0] data_base;
        logic [16:0] ring_end;
        logic [7:0]  record_size;
    } cfg_t;

    // one queued job for the back end
    typedef struct packed {
        desc_kind_t  kind;
        logic [15:0] addr;
        logic [7:0]  rec_len;
        logic [7:0]  first_len;
        logic        split;
        logic [7:0]  handle;
        logic        meta_due;
        logic [15:0] head;
        logic [31:0] count;
        logic [15:0] crc;
    } desc_t;

    typedef struct packed {
        cmd_kind_t   command_kind;
        logic [15:0] write_address;
        logic [7:0]  write_length;
        logic [6:0]  source_offset;
        logic [7:0]  handle_out;
        logic [15:0] meta_head;
        logic [31:0] meta_count;
        logic [15:0] meta_crc;
        logic        restored;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        done;
        logic [15:0] crc;
    } crc_res_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int j = 0; j < 8; j++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/ering_crc.sv
`timescale 1ns / 1ps
// byte-serial crc-16/ccitt engine over the 12-byte metadata word
// depends on ering_pkg

module ering_crc import ering_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [95:0] word,
    output crc_res_t    res
);

    logic [95:0] shift_reg;
    logic [15:0] crc_reg;
    logic [3:0]  left_reg;

    // least significant byte goes first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (start) begin
            left_reg <= META_BYTES;
        end else if (left_reg != '0) begin
            left_reg <= left_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= word;
            crc_reg   <= CRC_INIT;
        end else if (left_reg != '0) begin
            shift_reg <= {8'h00, shift_reg[95:8]};
            crc_reg   <= crc_byte(crc_reg, shift_reg[7:0]);
        end
    end

    assign res.done = (left_reg == '0);
    assign res.crc  = crc_reg;

endmodule

// File: rtl/ering_fifo.sv
`timescale 1ns / 1ps
// short job queue between the front and back ends
// depends on ering_pkg

module ering_fifo import ering_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t head_desc,
    output logic  full,
    output logic  empty
);

    desc_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    fill_reg;

    assign full      = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty     = (fill_reg == '0);
    assign head_desc = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (QUEUE_AW+1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// File: rtl/ering_front.sv
`timescale 1ns / 1ps
// front end: accepts beats, keeps head and count, checks restores, queues jobs
// depends on ering_pkg and ering_crc

module ering_front import ering_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_record_handle,
    input  logic [31:0] s_stored_magic,
    input  logic [31:0] s_stored_head,
    input  logic [31:0] s_stored_count,
    input  logic [15:0] s_stored_crc,
    output logic        push,
    output desc_t       push_desc,
    input  logic        q_full
);

    front_state_t fr_state_reg, fr_state_next;
    logic [15:0]  head_reg, head_next;
    logic [31:0]  count_reg, count_next;
    logic [31:0]  sv_magic_reg, sv_head_reg, sv_count_reg;
    logic [15:0]  sv_crc_reg;

    logic         accept;
    logic         crc_start;
    crc_res_t     crc_res;

    logic [SPAN_W-1:0] first_span;
    logic              split;
    logic [16:0]       adv;
    logic [31:0]       count_inc;
    logic              pass;

    ering_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (crc_start),
        .word    ({s_stored_count, s_stored_head, s_stored_magic}),
        .res     (crc_res)
    );

    assign s_ready   = (fr_state_reg == FR_IDLE) && !q_full;
    assign accept    = s_valid && s_ready;
    assign crc_start = accept && (s_opcode == OP_RESTORE);

    // bytes left in the current page, split when the record does not fit
    assign first_span = SPAN_W'(PAGE_BYTES) - SPAN_W'(head_reg[PAGE_LOG-1:0]);
    assign split      = first_span < SPAN_W'(cfg.record_size);
    assign adv        = {1'b0, head_reg} + 17'(cfg.record_size);
    assign count_inc  = count_reg + 32'd1;

    assign pass = (sv_magic_reg == cfg.meta_magic) && (crc_res.crc == sv_crc_reg) &&
                  (sv_head_reg >= {16'h0000, cfg.data_base}) &&
                  (sv_head_reg < {15'h0000, cfg.ring_end});

    always_comb begin
        fr_state_next = fr_state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        push          = 1'b0;
        push_desc     = '0;
        push_desc.kind      = DESC_RECORD;
        push_desc.addr      = head_reg;
        push_desc.rec_len   = cfg.record_size;
        push_desc.first_len = first_span[7:0];
        push_desc.split     = split;
        push_desc.handle    = s_record_handle;
        push_desc.meta_due  = (count_inc[3:0] & META_EVERY_MASK) == 4'h0;
        unique case (fr_state_reg)
            FR_IDLE: begin
                if (accept) begin
                    if (s_opcode == OP_RECORD) begin
                        push       = 1'b1;
                        head_next  = (adv >= cfg.ring_end) ? cfg.data_base : adv[15:0];
                        count_next = count_inc;
                        push_desc.head  = head_next;
                        push_desc.count = count_inc;
                    end else begin
                        fr_state_next = FR_CHECK;
                    end
                end
            end
            FR_CHECK: begin
                if (crc_res.done && !q_full) begin
                    push          = 1'b1;
                    fr_state_next = FR_IDLE;
                    if (pass) begin
                        head_next      = sv_head_reg[15:0];
                        count_next     = sv_count_reg;
                        push_desc.kind = DESC_STATUS;
                        push_desc.crc  = sv_crc_reg;
                    end else begin
                        head_next      = cfg.data_base;
                        count_next     = '0;
                        push_desc.kind = DESC_META;
                    end
                    push_desc.head  = head_next;
                    push_desc.count = count_next;
                end
            end
            default: begin
                fr_state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_state_reg <= FR_IDLE;
            head_reg     <= DATA_BASE_RST;
            count_reg    <= '0;
        end else begin
            fr_state_reg <= fr_state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (crc_start) begin
            sv_magic_reg <= s_stored_magic;
            sv_head_reg  <= s_stored_head;
            sv_count_reg <= s_stored_count;
            sv_crc_reg   <= s_stored_crc;
        end
    end

endmodule

// File: rtl/ering_back.sv
`timescale 1ns / 1ps
// back end: turns queued jobs into write commands through an output register
// depends on ering_pkg and ering_crc

module ering_back import ering_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  q_empty,
    input  desc_t q_desc,
    output logic  pop,
    output logic  m_valid,
    input  logic  m_ready,
    output res_t  m_res
);

    back_state_t bk_state_reg, bk_state_next;
    desc_t       job_reg;
    res_t        res_reg, res_next;
    logic        valid_reg;
    logic        out_free;
    logic        out_load;
    logic        crc_start;
    crc_res_t    crc_res;

    ering_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (crc_start),
        .word    ({q_desc.count, 16'h0000, q_desc.head, cfg.meta_magic}),
        .res     (crc_res)
    );

    assign out_free  = !valid_reg || m_ready;
    assign pop       = (bk_state_reg == BK_IDLE) && !q_empty;
    // crc runs while the data chunks go out
    assign crc_start = pop && ((q_desc.kind == DESC_META) ||
                               ((q_desc.kind == DESC_RECORD) && q_desc.meta_due));

    always_comb begin
        bk_state_next = bk_state_reg;
        out_load      = 1'b0;
        res_next      = '0;
        res_next.command_kind = CMD_DATA;
        unique case (bk_state_reg)
            BK_IDLE: begin
                if (pop) begin
                    unique case (q_desc.kind)
                        DESC_RECORD: bk_state_next = BK_CHUNK0;
                        DESC_META:   bk_state_next = BK_META;
                        DESC_STATUS: bk_state_next = BK_STATUS;
                        default:     bk_state_next = BK_IDLE;
                    endcase
                end
            end
            BK_CHUNK0: begin
                res_next.write_address = job_reg.addr;
                res_next.write_length  = job_reg.split ? job_reg.first_len : job_reg.rec_len;
                res_next.handle_out    = job_reg.handle;
                res_next.last          = !job_reg.split && !job_reg.meta_due;
                if (out_free) begin
                    out_load = 1'b1;
                    if (job_reg.split) begin
                        bk_state_next = BK_CHUNK1;
                    end else if (job_reg.meta_due) begin
                        bk_state_next = BK_META;
                    end else begin
                        bk_state_next = BK_IDLE;
                    end
                end
            end
            BK_CHUNK1: begin
                res_next.write_address = job_reg.addr + {8'h00, job_reg.first_len};
                res_next.write_length  = job_reg.rec_len - job_reg.first_len;
                res_next.source_offset = job_reg.first_len[6:0];
                res_next.handle_out    = job_reg.handle;
                res_next.last          = !job_reg.meta_due;
                if (out_free) begin
                    out_load      = 1'b1;
                    bk_state_next = job_reg.meta_due ? BK_META : BK_IDLE;
                end
            end
            BK_META: begin
                res_next.command_kind  = CMD_META;
                res_next.write_address = cfg.meta_address;
                res_next.write_length  = META_LEN;
                res_next.meta_head     = job_reg.head;
                res_next.meta_count    = job_reg.count;
                res_next.meta_crc      = crc_res.crc;
                res_next.last          = 1'b1;
                if (out_free && crc_res.done) begin
                    out_load      = 1'b1;
                    bk_state_next = BK_IDLE;
                end
            end
            BK_STATUS: begin
                res_next.command_kind = CMD_STATUS;
                res_next.meta_head    = job_reg.head;
                res_next.meta_count   = job_reg.count;
                res_next.meta_crc     = job_reg.crc;
                res_next.restored     = 1'b1;
                res_next.last         = 1'b1;
                if (out_free) begin
                    out_load      = 1'b1;
                    bk_state_next = BK_IDLE;
                end
            end
            default: begin
                bk_state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bk_state_reg <= BK_IDLE;
            valid_reg    <= 1'b0;
        end else begin
            bk_state_reg <= bk_state_next;
            if (out_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= q_desc;
        end
        if (out_load) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// File: rtl/eeprom_ring_log_writer_unit.sv
`timescale 1ns / 1ps
// Write-command generator for a record log kept as a ring in page-organised EEPROM.
// A record beat is taken while no restore check runs and the four-entry job queue has
// room; the back end picks up each job and then puts out one command per cycle while
// the receiver takes them, two for a record split at a page boundary. Every 16th record
// adds a metadata write whose CRC comes from a byte-serial engine started when the job
// is picked up; that write waits for the CRC. A restore beat holds the input until the
// CRC check of the stored metadata is done and its job is queued. Configuration writes are
// taken in any cycle (cfg_ready is always high) but must only be issued while the block
// is idle.
// depends on ering_pkg, ering_front, ering_fifo and ering_back

module eeprom_ring_log_writer_unit import ering_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_record_handle,
    input  logic [31:0] s_stored_magic,
    input  logic [31:0] s_stored_head,
    input  logic [31:0] s_stored_count,
    input  logic [15:0] s_stored_crc,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_command_kind,
    output logic [15:0] m_write_address,
    output logic [7:0]  m_write_length,
    output logic [6:0]  m_source_offset,
    output logic [7:0]  m_handle_out,
    output logic [15:0] m_meta_head,
    output logic [31:0] m_meta_count,
    output logic [15:0] m_meta_crc,
    output logic        m_restored,
    output logic        m_last
);

    logic [31:0] meta_magic_reg;
    logic [15:0] meta_address_reg;
    logic [15:0] data_base_reg;
    logic [16:0] ring_end_reg;
    logic [7:0]  record_size_reg;

    cfg_t  cfg;
    logic  push;
    desc_t push_desc;
    logic  pop;
    desc_t q_desc;
    logic  q_full;
    logic  q_empty;
    res_t  m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_magic_reg   <= META_MAGIC_RST;
            meta_address_reg <= META_ADDRESS_RST;
            data_base_reg    <= DATA_BASE_RST;
            ring_end_reg     <= RING_END_RST;
            record_size_reg  <= RECORD_SIZE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_META_MAGIC:   meta_magic_reg   <= cfg_data;
                CFG_META_ADDRESS: meta_address_reg <= cfg_data[15:0];
                CFG_DATA_BASE:    data_base_reg    <= cfg_data[15:0];
                CFG_RING_END:     ring_end_reg     <= cfg_data[16:0];
                CFG_RECORD_SIZE:  record_size_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // clamp ring end to the address space and record size to one page, zero taken as one
    always_comb begin
        cfg.meta_magic   = meta_magic_reg;
        cfg.meta_address = meta_address_reg;
        cfg.data_base    = data_base_reg;
        cfg.ring_end     = (ring_end_reg > ADDR_SPACE_END) ? ADDR_SPACE_END : ring_end_reg;
        priority if (record_size_reg == 8'd0) begin
            cfg.record_size = RECORD_MIN;
        end else if (record_size_reg > RECORD_MAX) begin
            cfg.record_size = RECORD_MAX;
        end else begin
            cfg.record_size = record_size_reg;
        end
    end

    ering_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_record_handle (s_record_handle),
        .s_stored_magic  (s_stored_magic),
        .s_stored_head   (s_stored_head),
        .s_stored_count  (s_stored_count),
        .s_stored_crc    (s_stored_crc),
        .push            (push),
        .push_desc       (push_desc),
        .q_full          (q_full)
    );

    ering_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (q_desc),
        .full      (q_full),
        .empty     (q_empty)
    );

    ering_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_desc  (q_desc),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_command_kind  = m_res.command_kind;
    assign m_write_address = m_res.write_address;
    assign m_write_length  = m_res.write_length;
    assign m_source_offset = m_res.source_offset;
    assign m_handle_out    = m_res.handle_out;
    assign m_meta_head     = m_res.meta_head;
    assign m_meta_count    = m_res.meta_count;
    assign m_meta_crc      = m_res.meta_crc;
    assign m_restored      = m_res.restored;
    assign m_last          = m_res.last;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for eeprom_ring_log_writer_unit: random bursts of record and restore beats,
// register phases between drains, every command checked against an in-bench predictor
// depends on ering_pkg and the rtl of eeprom_ring_log_writer_unit

module tb_top;
    import ering_pkg::*;

    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_BEATS    = 21;
    localparam int DRAIN_QUIET    = 16;
    localparam int TAIL_CYCLES    = 40;
    localparam int HOLDOFF_CYCLES = 150;

    typedef enum logic [1:0] {
        STEP_BEAT,
        STEP_REG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic        opcode;
        logic [7:0]  handle;
        logic [31:0] magic;
        logic [31:0] head;
        logic [31:0] count;
        logic [15:0] crc;
        logic [2:0]  reg_index;
        logic [31:0] reg_data;
    } step_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = 1'b0;
    logic [7:0]  s_record_handle = '0;
    logic [31:0] s_stored_magic = '0;
    logic [31:0] s_stored_head = '0;
    logic [31:0] s_stored_count = '0;
    logic [15:0] s_stored_crc = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_command_kind;
    logic [15:0] m_write_address;
    logic [7:0]  m_write_length;
    logic [6:0]  m_source_offset;
    logic [7:0]  m_handle_out;
    logic [15:0] m_meta_head;
    logic [31:0] m_meta_count;
    logic [15:0] m_meta_crc;
    logic        m_restored;
    logic        m_last;

    step_t log_steps[$];
    res_t  expected_cmds[$];
    step_t offered_step;

    // register file as the bench plans it and as the block holds it
    cfg_t plan_cfg = {META_MAGIC_RST, META_ADDRESS_RST, DATA_BASE_RST, RING_END_RST,
                      RECORD_SIZE_RST};
    cfg_t live_cfg = {META_MAGIC_RST, META_ADDRESS_RST, DATA_BASE_RST, RING_END_RST,
                      RECORD_SIZE_RST};
    logic [15:0] head_addr = DATA_BASE_RST;
    logic [31:0] record_total = '0;

    int beats_sent = 0;
    int restore_beats = 0;
    int restores_taken = 0;
    int reg_writes = 0;
    int commands_checked = 0;
    int page_splits = 0;
    int meta_writes = 0;
    int fail_count = 0;
    int holdoff_at = 0;

    int burst_left = 1;
    int gap_left = 0;
    int quiet_cycles = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;
    logic [6:0] stall_phase = '0;

    eeprom_ring_log_writer_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_record_handle (s_record_handle),
        .s_stored_magic  (s_stored_magic),
        .s_stored_head   (s_stored_head),
        .s_stored_count  (s_stored_count),
        .s_stored_crc    (s_stored_crc),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_command_kind  (m_command_kind),
        .m_write_address (m_write_address),
        .m_write_length  (m_write_length),
        .m_source_offset (m_source_offset),
        .m_handle_out    (m_handle_out),
        .m_meta_head     (m_meta_head),
        .m_meta_count    (m_meta_count),
        .m_meta_crc      (m_meta_crc),
        .m_restored      (m_restored),
        .m_last          (m_last)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // crc-16/ccitt over magic, head and count, each sent low byte first
    function automatic logic [15:0] meta_block_crc(input logic [31:0] magic,
                                                   input logic [31:0] head,
                                                   input logic [31:0] count);
        logic [95:0] block;
        logic [15:0] crc;
        block = {count, head, magic};
        crc = CRC_INIT;
        for (int k = 0; k < 12; k++) begin
            crc = crc ^ {block[8*k +: 8], 8'h00};
            for (int j = 0; j < 8; j++) begin
                if (crc[15]) begin
                    crc = {crc[14:0], 1'b0} ^ CRC_POLY;
                end else begin
                    crc = {crc[14:0], 1'b0};
                end
            end
        end
        return crc;
    endfunction

    function automatic logic [16:0] ring_end_eff(input logic [16:0] ring_end);
        return (ring_end > ADDR_SPACE_END) ? ADDR_SPACE_END : ring_end;
    endfunction

    function automatic logic [7:0] record_size_eff(input logic [7:0] size);
        if (size < RECORD_MIN) return RECORD_MIN;
        if (size > RECORD_MAX) return RECORD_MAX;
        return size;
    endfunction

    function automatic cfg_t with_reg(input cfg_t c, input logic [2:0] idx,
                                      input logic [31:0] data);
        cfg_t n;
        n = c;
        case (idx)
            CFG_META_MAGIC:   n.meta_magic = data;
            CFG_META_ADDRESS: n.meta_address = data[15:0];
            CFG_DATA_BASE:    n.data_base = data[15:0];
            CFG_RING_END:     n.ring_end = data[16:0];
            CFG_RECORD_SIZE:  n.record_size = data[7:0];
            default: ;
        endcase
        return n;
    endfunction

    function automatic void push_meta_write();
        res_t r;
        r = '0;
        r.command_kind = CMD_META;
        r.write_address = live_cfg.meta_address;
        r.write_length = META_LEN;
        r.meta_head = head_addr;
        r.meta_count = record_total;
        r.meta_crc = meta_block_crc(live_cfg.meta_magic, {16'd0, head_addr}, record_total);
        r.last = 1'b1;
        expected_cmds.push_back(r);
        meta_writes++;
    endfunction

    // works out the commands that one accepted beat causes and updates head and count
    function automatic void predict_log_commands(input step_t st);
        res_t r;
        res_t chunk_a;
        res_t chunk_b;
        logic [16:0] rend;
        logic [31:0] rsz;
        logic [31:0] first;
        logic [31:0] next_head;
        bit split;
        rend = ring_end_eff(live_cfg.ring_end);
        if (st.opcode == OP_RESTORE) begin
            restore_beats++;
            if (st.magic == live_cfg.meta_magic &&
                st.crc == meta_block_crc(st.magic, st.head, st.count) &&
                st.head >= {16'd0, live_cfg.data_base} && st.head < {15'd0, rend}) begin
                head_addr = st.head[15:0];
                record_total = st.count;
                r = '0;
                r.command_kind = CMD_STATUS;
                r.meta_head = head_addr;
                r.meta_count = record_total;
                r.meta_crc = st.crc;
                r.restored = 1'b1;
                r.last = 1'b1;
                expected_cmds.push_back(r);
                restores_taken++;
            end else begin
                head_addr = live_cfg.data_base;
                record_total = '0;
                push_meta_write();
            end
        end else begin
            rsz = {24'd0, record_size_eff(live_cfg.record_size)};
            first = PAGE_BYTES - ({16'd0, head_addr} % PAGE_BYTES);
            split = first < rsz;
            chunk_a = '0;
            chunk_a.command_kind = CMD_DATA;
            chunk_a.write_address = head_addr;
            chunk_a.handle_out = st.handle;
            chunk_a.write_length = split ? first[7:0] : rsz[7:0];
            chunk_b = chunk_a;
            chunk_b.write_address = head_addr + first[15:0];
            chunk_b.write_length = rsz[7:0] - first[7:0];
            chunk_b.source_offset = first[6:0];

            next_head = {16'd0, head_addr} + rsz;
            if (next_head >= {15'd0, rend}) begin
                head_addr = live_cfg.data_base;
            end else begin
                head_addr = next_head[15:0];
            end
            record_total = record_total + 32'd1;

            if ((record_total[3:0] & META_EVERY_MASK) != 4'd0) begin
                if (split) chunk_b.last = 1'b1;
                else chunk_a.last = 1'b1;
            end
            expected_cmds.push_back(chunk_a);
            if (split) begin
                expected_cmds.push_back(chunk_b);
                page_splits++;
            end
            if ((record_total[3:0] & META_EVERY_MASK) == 4'd0) push_meta_write();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void queue_drain();
        step_t st;
        st = '0;
        st.kind = STEP_DRAIN;
        log_steps.push_back(st);
    endfunction

    function automatic void queue_reg_write(input logic [2:0] idx, input logic [31:0] data);
        step_t st;
        st = '0;
        st.kind = STEP_REG;
        st.reg_index = idx;
        st.reg_data = data;
        plan_cfg = with_reg(plan_cfg, idx, data);
        log_steps.push_back(st);
    endfunction

    function automatic void queue_record(input logic [7:0] handle);
        step_t st;
        st = '0;
        st.kind = STEP_BEAT;
        st.opcode = OP_RECORD;
        st.handle = handle;
        // restore fields carry noise on record beats
        st.magic = $urandom;
        st.head = $urandom;
        st.count = $urandom;
        st.crc = 16'($urandom_range(0, 65535));
        log_steps.push_back(st);
    endfunction

    function automatic void queue_restore(input logic [31:0] magic, input logic [31:0] head,
                                          input logic [31:0] count, input logic [15:0] crc);
        step_t st;
        st = '0;
        st.kind = STEP_BEAT;
        st.opcode = OP_RESTORE;
        st.handle = 8'($urandom_range(0, 255));
        st.magic = magic;
        st.head = head;
        st.count = count;
        st.crc = crc;
        log_steps.push_back(st);
    endfunction

    function automatic void queue_sealed_restore(input logic [31:0] magic,
                                                 input logic [31:0] head,
                                                 input logic [31:0] count);
        queue_restore(magic, head, count, meta_block_crc(magic, head, count));
    endfunction

    // sender: bursts of beats with gaps, register writes and drains from the step queue
    always @(posedge aclk) begin : sender
        logic beat_busy;
        logic reg_busy;
        step_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            beat_busy = s_valid;
            reg_busy = cfg_valid;
            if (s_valid && s_ready) begin
                predict_log_commands(offered_step);
                beats_sent++;
                beat_busy = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                live_cfg = with_reg(live_cfg, cfg_index, cfg_data);
                reg_writes++;
                reg_busy = 1'b0;
            end
            if (!beat_busy && !reg_busy && log_steps.size() != 0) begin
                nxt = log_steps[0];
                case (nxt.kind)
                    STEP_DRAIN: begin
                        if (expected_cmds.size() == 0 && !m_valid) quiet_cycles++;
                        else quiet_cycles = 0;
                        if (quiet_cycles >= DRAIN_QUIET) begin
                            quiet_cycles = 0;
                            log_steps.delete(0);
                        end
                    end
                    STEP_REG: begin
                        log_steps.delete(0);
                        cfg_index <= nxt.reg_index;
                        cfg_data <= nxt.reg_data;
                        reg_busy = 1'b1;
                    end
                    default: begin
                        if (gap_left != 0) begin
                            gap_left--;
                        end else begin
                            log_steps.delete(0);
                            offered_step = nxt;
                            s_opcode <= nxt.opcode;
                            s_record_handle <= nxt.handle;
                            s_stored_magic <= nxt.magic;
                            s_stored_head <= nxt.head;
                            s_stored_count <= nxt.count;
                            s_stored_crc <= nxt.crc;
                            beat_busy = 1'b1;
                            if (burst_left > 1) begin
                                burst_left--;
                            end else begin
                                burst_left = ($urandom_range(0, 3) == 0) ?
                                             $urandom_range(20, 40) : $urandom_range(1, 8);
                                gap_left = ($urandom_range(0, 3) == 0) ?
                                           0 : $urandom_range(1, 10);
                            end
                        end
                    end
                endcase
            end
            s_valid <= beat_busy;
            cfg_valid <= reg_busy;
        end
    end

    // receiver: free stretch, random stalls, sparse acceptance, one long hold-off
    always @(posedge aclk) begin : receiver
        res_t want;
        logic take;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                commands_checked++;
                if (expected_cmds.size() == 0) begin
                    $error("command beat with nothing expected: kind %0d address 0x%0h",
                           m_command_kind, m_write_address);
                    fail_count++;
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("command_kind", 32'(want.command_kind), 32'(m_command_kind));
                    check_field("write_address", 32'(want.write_address),
                                32'(m_write_address));
                    check_field("write_length", 32'(want.write_length), 32'(m_write_length));
                    check_field("source_offset", 32'(want.source_offset),
                                32'(m_source_offset));
                    check_field("handle_out", 32'(want.handle_out), 32'(m_handle_out));
                    check_field("meta_head", 32'(want.meta_head), 32'(m_meta_head));
                    check_field("meta_count", want.meta_count, m_meta_count);
                    check_field("meta_crc", 32'(want.meta_crc), 32'(m_meta_crc));
                    check_field("restored", 32'(want.restored), 32'(m_restored));
                    check_field("last", 32'(want.last), 32'(m_last));
                end
            end
            stall_phase = stall_phase + 7'd1;
            if (holdoff_left != 0) begin
                holdoff_left--;
                take = 1'b0;
            end else if (!holdoff_done && holdoff_at != 0 && beats_sent >= holdoff_at) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                take = 1'b0;
            end else if (stall_phase < 7'd32) begin
                take = 1'b1;
            end else if (stall_phase < 7'd96) begin
                take = $urandom_range(0, 99) < 55;
            end else begin
                take = stall_phase[1:0] == 2'd0;
            end
            m_ready <= take;
        end
    end

    initial begin : stimulus
        logic [31:0] rs;
        logic [31:0] base;
        logic [31:0] span;
        logic [31:0] cfg_word;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] rhead;
        logic [31:0] rcount;
        logic [31:0] pick;
        int directed_beats;

        // reset register values: magic 0, ring 128..32768, 16-byte records
        queue_record(8'h00);
        queue_restore(32'h1, 32'd128, 32'd0, 16'h0);
        queue_sealed_restore(32'h0, 32'd32767, 32'hFFFF_FFFF);
        queue_record(8'hFF);    // page split at ring top, wrap to base, count wraps to zero
        queue_sealed_restore(32'h0, 32'd128, 32'h0000_000E);
        queue_record(8'h55);
        queue_record(8'hAA);
        queue_sealed_restore(32'h0, 32'd32768, 32'd5);
        queue_sealed_restore(32'h0, 32'd127, 32'd5);
        queue_sealed_restore(32'h0, 32'h0001_0080, 32'd9);   // low half in range only
        queue_restore(32'h0, 32'd200, 32'd7, meta_block_crc(32'h0, 32'd200, 32'd7) ^ 16'h1);

        // top of the address space, size 0 taken as 1
        queue_drain();
        queue_reg_write(CFG_META_MAGIC, 32'hFFFF_FFFF);
        queue_reg_write(CFG_META_ADDRESS, 32'h0000_FFFF);
        queue_reg_write(CFG_DATA_BASE, 32'h0000_FFFF);
        queue_reg_write(CFG_RING_END, 32'h0001_FFFF);
        queue_reg_write(CFG_RECORD_SIZE, 32'd0);
        queue_restore(32'h0, 32'h0, 32'h0, 16'h0);
        queue_record(8'h0F);
        queue_drain();
        queue_reg_write(CFG_RECORD_SIZE, 32'd16);
        queue_record(8'hF0);    // second chunk wraps to address zero
        queue_drain();
        queue_reg_write(CFG_RECORD_SIZE, 32'd200);
        queue_record(8'h3C);

        // empty ring
        queue_drain();
        queue_reg_write(CFG_DATA_BASE, 32'd0);
        queue_reg_write(CFG_RING_END, 32'd0);
        queue_reg_write(CFG_RECORD_SIZE, 32'd128);
        queue_restore(32'h0, 32'h0, 32'h0, 16'h0);
        queue_record(8'hC3);

        queue_drain();
        queue_reg_write(CFG_META_MAGIC, 32'hA5A5_5A5A);
        queue_reg_write(CFG_DATA_BASE, 32'h100);
        queue_reg_write(CFG_RING_END, 32'h300);
        queue_reg_write(CFG_RECORD_SIZE, 32'd129);
        queue_sealed_restore(32'hA5A5_5A5A, 32'h2FF, 32'h7FFF_FFFF);
        queue_record(8'h81);
        queue_record(8'h7E);
        queue_sealed_restore(32'hA5A5_5A5A, 32'h100, 32'h8000_000F);
        queue_record(8'h18);
        directed_beats = 22;
        holdoff_at = directed_beats + 26;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 2))
                0: rs = $urandom_range(1, 20);
                1: rs = $urandom_range(0, 255);
                default: begin
                    case ($urandom_range(0, 2))
                        0: rs = 32'd1;
                        1: rs = 32'd127;
                        default: rs = 32'd128;
                    endcase
                end
            endcase
            base = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 65535);
            span = record_size_eff(rs[7:0]) * $urandom_range(2, 12) + $urandom_range(0, 127);
            queue_drain();
            queue_reg_write(CFG_META_MAGIC, $urandom);
            // upper bits beyond each register's width are junk and must be dropped
            cfg_word = $urandom;
            pick = $urandom_range(0, 65535);
            cfg_word[15:0] = pick[15:0];
            queue_reg_write(CFG_META_ADDRESS, cfg_word);
            cfg_word = $urandom;
            cfg_word[15:0] = base[15:0];
            queue_reg_write(CFG_DATA_BASE, cfg_word);
            cfg_word = $urandom;
            pick = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071) : base + span;
            cfg_word[16:0] = pick[16:0];
            queue_reg_write(CFG_RING_END, cfg_word);
            cfg_word = $urandom;
            cfg_word[7:0] = rs[7:0];
            queue_reg_write(CFG_RECORD_SIZE, cfg_word);

            for (int i = 0; i < PHASE_BEATS; i++) begin
                if ($urandom_range(0, 99) < 65) begin
                    pick = $urandom_range(0, 255);
                    queue_record(pick[7:0]);
                end else begin
                    lo = {16'd0, plan_cfg.data_base};
                    hi = {15'd0, ring_end_eff(plan_cfg.ring_end)};
                    rhead = (hi > lo) ? $urandom_range(hi - 1, lo) : lo;
                    case ($urandom_range(0, 2))
                        0: rcount = $urandom;
                        1: rcount = ($urandom_range(0, 32'h0FFF_FFFF) << 4) | 32'hF;
                        default: rcount = $urandom_range(0, 40);
                    endcase
                    case ($urandom_range(0, 7))
                        4: queue_sealed_restore(plan_cfg.meta_magic ^
                                                (32'd1 << $urandom_range(0, 31)), rhead, rcount);
                        5: queue_restore(plan_cfg.meta_magic, rhead, rcount,
                                         meta_block_crc(plan_cfg.meta_magic, rhead, rcount) ^
                                         (16'd1 << $urandom_range(0, 15)));
                        6: begin
                            case ($urandom_range(0, 2))
                                0: rhead = $urandom;
                                1: rhead = hi;
                                default: rhead = (lo != 0) ? lo - 32'd1 : hi;
                            endcase
                            queue_sealed_restore(plan_cfg.meta_magic, rhead, rcount);
                        end
                        7: begin
                            pick = $urandom_range(0, 65535);
                            queue_restore($urandom, $urandom, $urandom, pick[15:0]);
                        end
                        default: queue_sealed_restore(plan_cfg.meta_magic, rhead, rcount);
                    endcase
                end
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (log_steps.size() != 0 || s_valid || cfg_valid) @(posedge aclk);
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (expected_cmds.size() != 0) begin
            $error("%0d expected commands never arrived", expected_cmds.size());
            fail_count++;
        end
        $display("Covered %0d beats (%0d restores, %0d taken) over %0d register writes.",
                 beats_sent, restore_beats, restores_taken, reg_writes);
        $display("Checked %0d commands: %0d split records, %0d metadata writes, %0d errors.",
                 commands_checked, page_splits, meta_writes, fail_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
